>>> hw/rtl/lmtd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the LED matrix temperature scanner.
// No dependencies.
package lmtd_pkg;

  localparam logic [15:0] IDLE_WORD = 16'h003F;
  localparam logic [7:0]  FAHR_MAX  = 8'd199;
  localparam logic [7:0]  FAHR_OFS  = 8'd32;
  localparam logic [3:0]  LEVEL_MAX = 4'd9;
  localparam logic [3:0]  HOT_LEVEL = 4'd6;
  localparam int          BAR_ROWS  = 9;
  localparam int          BAR_TOP   = 14;

  // Scan phase codes
  localparam logic [2:0] PH_HUNDREDS = 3'd0;
  localparam logic [2:0] PH_TENS     = 3'd1;
  localparam logic [2:0] PH_UNITS    = 3'd2;
  localparam logic [2:0] PH_BAR      = 3'd3;
  localparam logic [2:0] PH_HOT      = 3'd4;
  localparam logic [2:0] PH_UNIT     = 3'd5;
  localparam logic [2:0] PH_TREND    = 3'd6;

  typedef struct packed {
    logic [7:0] shown_number;
    logic [3:0] bar_level;
    logic       celsius_mode;
    logic       trend_flag;
  } scan_state_t;

  // n/10 for n < 256: multiply by 205/2048
  function automatic logic [4:0] div10_u8(input logic [7:0] n);
    logic [15:0] prod;
    prod = n * 16'd205;
    return prod[15:11];
  endfunction

  // Seven-segment code, bit 6 = a .. bit 0 = g
  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0: code = 7'b1111110;
      4'd1: code = 7'b0110000;
      4'd2: code = 7'b1101101;
      4'd3: code = 7'b1111001;
      4'd4: code = 7'b0110011;
      4'd5: code = 7'b1011011;
      4'd6: code = 7'b1011111;
      4'd7: code = 7'b1110000;
      4'd8: code = 7'b1111111;
      4'd9: code = 7'b1111011;
      default: code = 7'b0000000;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/lmtd_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one scan tick request.
// No dependencies.
interface lmtd_in_if;
  logic       valid;
  logic       ready;
  logic       key_press;
  logic       trend_load;
  logic       trend_lamp;
  logic       value_load;
  logic [7:0] celsius;

  modport source (output valid, key_press, trend_load, trend_lamp, value_load, celsius,
                  input ready);
  modport sink   (input valid, key_press, trend_load, trend_lamp, value_load, celsius,
                  output ready);
endinterface

>>> hw/rtl/lmtd_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one port word and its scan phase.
// No dependencies.
interface lmtd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] port_word;
  logic [2:0]  scan_phase;

  modport source (output valid, port_word, scan_phase, input ready);
  modport sink   (input valid, port_word, scan_phase, output ready);
endinterface

>>> hw/rtl/led_matrix_temp_display_scanner.sv
`timescale 1ns / 1ps
// Top level of the LED matrix temperature scanner.
// Depends on lmtd_pkg, lmtd_in_if, lmtd_out_if and lmtd_scan.

// Each input transaction is one refresh tick. The block drives one of seven scan
// phases (hundreds mark, tens digit, units digit, level bar, hot mark, unit lamp,
// trend lamp) in turn and returns the 16-bit port word: bits 0-5 are column lines,
// active low, bits 6-15 row lines, active high; a blank phase gives 0x003F. A key
// press toggles Celsius/Fahrenheit (Fahrenheit after reset) and a trend load latches
// the trend lamp, both before the tick's word is formed. A value load latches the new
// temperature after the word: the shown number (Fahrenheit conversion saturates at
// 199) and the bar level min(celsius/10, 9). Throughput is one transaction per clock:
// the word is decoded by shallow logic from the state registers and captured in a
// single output register, so the result appears the cycle after acceptance, and a new
// tick is taken whenever that register is empty or being drained.
module led_matrix_temp_display_scanner
  import lmtd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  lmtd_in_if.sink    in_chan,
  lmtd_out_if.source out_chan
);

  // State
  logic [2:0]  phase_cnt_r;
  logic [7:0]  shown_number_r;
  logic [3:0]  bar_level_r;
  logic        celsius_mode_r;
  logic        trend_flag_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_word_r;
  logic [2:0]  out_phase_r;

  logic        in_accept;
  logic [2:0]  phase_cur;
  logic [2:0]  phase_nxt;
  logic        celsius_mode_nxt;
  logic        trend_flag_nxt;
  scan_state_t scan_st;
  logic [15:0] scan_word;

  // Load conversion
  logic [11:0] c_x9;
  logic [25:0] f_prod;
  logic [11:0] f_div5;
  logic [11:0] f_full;
  logic [7:0]  shown_number_nxt;
  logic [4:0]  c_div10;
  logic [3:0]  bar_level_nxt;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // counter code 7 never occurs; treat it as the hundreds phase anyway
  assign phase_cur = (phase_cnt_r > PH_TREND) ? PH_HUNDREDS : phase_cnt_r;
  assign phase_nxt = (phase_cur == PH_TREND) ? PH_HUNDREDS : phase_cur + 3'd1;

  assign celsius_mode_nxt = celsius_mode_r ^ in_chan.key_press;
  assign trend_flag_nxt   = in_chan.trend_load ? in_chan.trend_lamp : trend_flag_r;

  assign scan_st = '{shown_number: shown_number_r, bar_level: bar_level_r,
                     celsius_mode: celsius_mode_nxt, trend_flag: trend_flag_nxt};

  lmtd_scan u_scan (
    .phase (phase_cur),
    .st    (scan_st),
    .word  (scan_word)
  );

  // celsius*9/5 + 32: x/5 as x*3277 >> 14, exact for x below 5000
  assign c_x9   = {1'b0, in_chan.celsius, 3'b000} + {4'h0, in_chan.celsius};
  assign f_prod = c_x9 * 14'd3277;
  assign f_div5 = f_prod[25:14];
  assign f_full = f_div5 + {4'h0, FAHR_OFS};

  always_comb begin
    if (celsius_mode_nxt) begin
      shown_number_nxt = in_chan.celsius;
    end else if (f_full > {4'h0, FAHR_MAX}) begin
      shown_number_nxt = FAHR_MAX;
    end else begin
      shown_number_nxt = f_full[7:0];
    end
  end

  assign c_div10       = div10_u8(in_chan.celsius);
  assign bar_level_nxt = (c_div10 > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : c_div10[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_cnt_r    <= PH_HUNDREDS;
      shown_number_r <= '0;
      bar_level_r    <= '0;
      celsius_mode_r <= 1'b0;
      trend_flag_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_cnt_r    <= phase_nxt;
        celsius_mode_r <= celsius_mode_nxt;
        trend_flag_r   <= trend_flag_nxt;
        if (in_chan.value_load) begin
          shown_number_r <= shown_number_nxt;
          bar_level_r    <= bar_level_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_word_r  <= scan_word;
      out_phase_r <= phase_cur;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.port_word  = out_word_r;
  assign out_chan.scan_phase = out_phase_r;

  // Assertions
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_cnt_r != 3'd7)
    else $error("phase counter left the seven-phase cycle");

  a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
    bar_level_r <= LEVEL_MAX)
    else $error("bar level above nine");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_chan.valid && (out_chan.scan_phase == $past(phase_cur)))
    else $error("tick transaction did not produce its phase word");

endmodule

>>> hw/rtl/lmtd_scan.sv
`timescale 1ns / 1ps
// Port word decode for one scan phase from the display state.
// Depends on lmtd_pkg.
module lmtd_scan
  import lmtd_pkg::*;
(
  input  logic [2:0]  phase,
  input  scan_state_t st,
  output logic [15:0] word
);

  logic [4:0] q10;
  logic [4:0] tens_full;
  logic [3:0] tens_digit;
  logic [3:0] units_digit;
  logic [7:0] q10_x10;
  logic [15:0] tens_word;
  logic [15:0] units_word;
  logic [15:0] bar_word;

  assign q10      = div10_u8(st.shown_number);
  assign q10_x10  = {q10, 3'b000} + {2'b00, q10, 1'b0};
  assign units_digit = 4'(st.shown_number - q10_x10);

  // q10 <= 25, so at most two subtractions of ten
  always_comb begin
    if (q10 >= 5'd20) begin
      tens_full = q10 - 5'd20;
    end else if (q10 >= 5'd10) begin
      tens_full = q10 - 5'd10;
    end else begin
      tens_full = q10;
    end
  end
  assign tens_digit = tens_full[3:0];

  assign tens_word  = (IDLE_WORD & ~16'h0002) | {1'b0, seg_code(tens_digit), 8'h00};
  assign units_word = (IDLE_WORD & ~16'h0004) | {1'b0, seg_code(units_digit), 8'h00};

  always_comb begin
    bar_word = IDLE_WORD & ~16'h0001;
    for (int i = 0; i < BAR_ROWS; i++) begin
      if (4'(i) < st.bar_level) begin
        bar_word[BAR_TOP - i] = 1'b1;
      end
    end
  end

  always_comb begin
    word = IDLE_WORD;
    case (phase)
      PH_TENS: begin
        if (st.shown_number >= 8'd10) word = tens_word;
      end
      PH_UNITS: begin
        word = units_word;
      end
      PH_BAR: begin
        word = bar_word;
      end
      PH_HOT: begin
        if (st.bar_level > HOT_LEVEL) word = (IDLE_WORD & ~16'h000C) | 16'h00C0;
      end
      PH_UNIT: begin
        word = (IDLE_WORD & ~16'h0020) | (st.celsius_mode ? 16'h0100 : 16'h0800);
      end
      PH_TREND: begin
        if (st.trend_flag) word = (IDLE_WORD & ~16'h0020) | 16'h7000;
      end
      default: begin
        if (st.shown_number >= 8'd100) word = (IDLE_WORD & ~16'h0020) | 16'h0600;
      end
    endcase
  end

endmodule

>>> tb/tb_led_matrix_temp_display_scanner.sv
`timescale 1ns / 1ps
// Self-checking bench for led_matrix_temp_display_scanner: tick driver, port monitor,
// and an in-bench scan predictor. Depends on lmtd_pkg, lmtd_in_if, lmtd_out_if.
module tb_led_matrix_temp_display_scanner
  import lmtd_pkg::*;
();

  // Seven-segment patterns, bit 6 = segment a .. bit 0 = segment g
  localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
    7'b1111110, 7'b0110000, 7'b1101101, 7'b1111001, 7'b0110011,
    7'b1011011, 7'b1011111, 7'b1110000, 7'b1111111, 7'b1111011
  };

  // Temperatures near every decode boundary: digit counts, bar steps, the
  // hot threshold and the Fahrenheit saturation point (93 C -> 199 F, 94 C -> 201 F)
  localparam logic [7:0] BOUNDARY_CELSIUS [14] = '{
    8'd0, 8'd9, 8'd10, 8'd60, 8'd69, 8'd70, 8'd93,
    8'd94, 8'd99, 8'd100, 8'd101, 8'd199, 8'd200, 8'd255
  };

  localparam int RANDOM_TICKS = 1050;
  localparam int HOLD_AFTER   = 400;  // sent count that starts the long receiver hold
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic        key_press;
    logic        trend_load;
    logic        trend_lamp;
    logic        value_load;
    logic [7:0]  celsius;
    logic        pause_for_drain;  // wait for all results before offering this one
    int unsigned gap_after;        // idle cycles after this transaction
  } scan_tick_t;

  typedef struct {
    logic [15:0] port_word;
    logic [2:0]  scan_phase;
  } scan_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Driven copies of the channel inputs, known from time zero
  logic       in_valid      = 1'b0;
  logic       in_key_press  = 1'b0;
  logic       in_trend_load = 1'b0;
  logic       in_trend_lamp = 1'b0;
  logic       in_value_load = 1'b0;
  logic [7:0] in_celsius    = 8'd0;
  logic       out_ready     = 1'b0;

  lmtd_in_if  in_chan();
  lmtd_out_if out_chan();

  assign in_chan.valid      = in_valid;
  assign in_chan.key_press  = in_key_press;
  assign in_chan.trend_load = in_trend_load;
  assign in_chan.trend_lamp = in_trend_lamp;
  assign in_chan.value_load = in_value_load;
  assign in_chan.celsius    = in_celsius;
  assign out_chan.ready     = out_ready;

  led_matrix_temp_display_scanner DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Queues between the stimulus, the driver and the monitor
  scan_tick_t   pending_ticks[$];
  scan_result_t expected_scans[$];
  scan_tick_t   cur_tick;

  // Predicted scanner state
  logic [2:0] phase_q;
  logic [7:0] number_q;
  logic [3:0] level_q;
  logic       celsius_mode_q;
  logic       trend_q;

  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned err_cnt  = 0;
  int unsigned tx_gap_left = 0;
  int unsigned rx_stall_left = 0;
  int          rx_mode = 0;
  logic        hold_rx = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Gap length by idling mode: 0 = none, 1 = light, 2 = mostly short, a few long
  function automatic int unsigned pick_gap(input int mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) return (roll < 70) ? 0 : $urandom_range(1, 3);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 15);
    return $urandom_range(20, 60);
  endfunction

  // Port word for one scan phase from the current predicted state.
  // Column n is bit n-1 (active low), row n is bit n (active high).
  function automatic logic [15:0] scan_port_word(input logic [2:0] phase);
    logic [15:0] w;
    w = IDLE_WORD;
    case (phase)
      PH_TENS: begin
        if (number_q >= 8'd10) begin
          w[1] = 1'b0;  // column 2
          w[14:8] = DIGIT_SEGMENTS[(number_q % 100) / 10];
        end
      end
      PH_UNITS: begin
        w[2] = 1'b0;  // column 3, always lit
        w[14:8] = DIGIT_SEGMENTS[number_q % 10];
      end
      PH_BAR: begin
        w[0] = 1'b0;  // column 1 even for an empty bar
        for (int i = 0; i < BAR_ROWS; i++)
          if (i < level_q) w[BAR_TOP - i] = 1'b1;
      end
      PH_HOT: begin
        if (level_q > HOT_LEVEL) begin
          w[2] = 1'b0;
          w[3] = 1'b0;
          w[6] = 1'b1;
          w[7] = 1'b1;
        end
      end
      PH_UNIT: begin
        w[5] = 1'b0;
        if (celsius_mode_q) w[8] = 1'b1;
        else w[11] = 1'b1;
      end
      PH_TREND: begin
        if (trend_q) begin
          w[5] = 1'b0;
          w[14:12] = 3'b111;
        end
      end
      default: begin
        // hundreds mark; an out-of-range counter code scans as this phase too
        if (number_q >= 8'd100) begin
          w[5] = 1'b0;
          w[9] = 1'b1;
          w[10] = 1'b1;
        end
      end
    endcase
    return w;
  endfunction

  // One accepted tick: key and trend first, then the scan word, then the load
  task automatic advance_scanner(input scan_tick_t t);
    scan_result_t r;
    logic [2:0] phase;
    int fahr;
    int lvl;
    phase = (phase_q > PH_TREND) ? PH_HUNDREDS : phase_q;
    if (t.key_press) celsius_mode_q = ~celsius_mode_q;
    if (t.trend_load) trend_q = t.trend_lamp;
    r.port_word = scan_port_word(phase);
    r.scan_phase = phase;
    expected_scans.push_back(r);
    phase_q = (phase == PH_TREND) ? PH_HUNDREDS : phase + 3'd1;
    if (t.value_load) begin
      if (celsius_mode_q) begin
        number_q = t.celsius;
      end else begin
        fahr = int'(t.celsius) * 9 / 5 + int'(FAHR_OFS);
        if (fahr > int'(FAHR_MAX)) fahr = int'(FAHR_MAX);
        number_q = fahr[7:0];
      end
      lvl = int'(t.celsius) / 10;
      if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
      level_q = lvl[3:0];
    end
  endtask

  task automatic queue_tick(input logic key, input logic tload, input logic tlamp,
                            input logic vload, input logic [7:0] c,
                            input int unsigned gap, input logic drain);
    scan_tick_t t;
    t.key_press = key;
    t.trend_load = tload;
    t.trend_lamp = tlamp;
    t.value_load = vload;
    t.celsius = c;
    t.gap_after = gap;
    t.pause_for_drain = drain;
    pending_ticks.push_back(t);
  endtask

  // Tick driver: records the prediction at each accepted transaction, then
  // presents the next pending tick unless a gap or a drain pause is due.
  always @(posedge clk) begin : tick_driver
    logic accepted;
    int unsigned sent_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
      phase_q = PH_HUNDREDS;
      number_q = 8'd0;
      level_q = 4'd0;
      celsius_mode_q = 1'b0;  // Fahrenheit after reset
      trend_q = 1'b0;
      tx_gap_left = 0;
    end else begin
      accepted = in_valid && in_chan.ready;
      sent_now = sent_cnt + (accepted ? 1 : 0);
      if (accepted) begin
        advance_scanner(cur_tick);
        sent_cnt <= sent_now;
      end
      if (!in_valid || accepted) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0 &&
                     (!pending_ticks[0].pause_for_drain || sent_now == recv_cnt)) begin
          cur_tick = pending_ticks.pop_front();
          in_key_press  <= cur_tick.key_press;
          in_trend_load <= cur_tick.trend_load;
          in_trend_lamp <= cur_tick.trend_lamp;
          in_value_load <= cur_tick.value_load;
          in_celsius    <= cur_tick.celsius;
          in_valid      <= 1'b1;
          tx_gap_left = cur_tick.gap_after;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Port monitor: checks each result transaction against the oldest prediction
  // and paces ready with random stalls; the idling mode changes every 128 results.
  always @(posedge clk) begin : port_monitor
    scan_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall_left = 0;
    end else begin
      if (out_chan.valid && out_ready) begin
        if (expected_scans.size() == 0) begin
          $error("unexpected result: port_word %h scan_phase %0d",
                 out_chan.port_word, out_chan.scan_phase);
          err_cnt++;
        end else begin
          want = expected_scans.pop_front();
          if (out_chan.port_word !== want.port_word) begin
            $error("port_word: expected %h, got %h", want.port_word, out_chan.port_word);
            err_cnt++;
          end
          if (out_chan.scan_phase !== want.scan_phase) begin
            $error("scan_phase: expected %0d, got %0d", want.scan_phase,
                   out_chan.scan_phase);
            err_cnt++;
          end
        end
        recv_cnt <= recv_cnt + 1;
        if ((recv_cnt + 1) % 128 == 0) rx_mode = $urandom_range(0, 2);
      end
      if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall_left = pick_gap(rx_mode);
      end
    end
  end

  // Long receiver hold while the sender keeps offering: fills the block and
  // forces it to back-pressure the input.
  initial begin
    wait (sent_cnt >= HOLD_AFTER);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    int tx_mode;
    logic [7:0] c;

    // Directed: reset state across all phases, then loads at the extremes,
    // unit toggles, trend on/off, hot threshold and Fahrenheit saturation.
    repeat (6) queue_tick(0, 0, 0, 0, 8'd0, 0, 0);   // blank marks, units 0, F lamp
    queue_tick(0, 1, 1, 1, 8'd255, 0, 0);            // trend on; 255 C -> 199 F, level 9
    repeat (5) queue_tick(0, 0, 0, 0, 8'd0, 0, 0);   // hundreds, 9, 9, full bar, hot
    queue_tick(1, 0, 0, 1, 8'd255, 0, 0);            // to Celsius, 255 shown unsaturated
    queue_tick(0, 1, 0, 0, 8'd0, 0, 0);              // trend off
    repeat (2) queue_tick(0, 0, 0, 0, 8'd0, 0, 0);
    queue_tick(0, 0, 0, 1, 8'd0, 0, 0);              // zero, empty bar
    queue_tick(0, 0, 0, 0, 8'd0, 0, 0);
    queue_tick(0, 0, 0, 1, 8'd70, 0, 0);             // level 7, hot
    queue_tick(1, 0, 0, 1, 8'd93, 0, 0);             // back to F: exactly 199
    queue_tick(0, 1, 1, 1, 8'd94, 0, 0);             // 201 F saturates
    queue_tick(1, 0, 0, 1, 8'd9, 0, 0);              // Celsius, single digit
    queue_tick(0, 0, 0, 1, 8'd60, 0, 0);             // tens blank; level 6
    repeat (2) queue_tick(0, 0, 0, 0, 8'd0, 0, 0);
    queue_tick(0, 0, 0, 1, 8'd100, 0, 0);            // level 6 is not hot

    // Random: mixed strobes, temperatures biased to boundaries, idling mode
    // rerolled every 100 ticks; two ticks wait for a full drain.
    tx_mode = 0;
    for (int i = 0; i < RANDOM_TICKS; i++) begin
      if (i % 100 == 0) tx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) c = BOUNDARY_CELSIUS[$urandom_range(0, 13)];
      else c = 8'($urandom_range(0, 255));
      queue_tick($urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
                 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0, c,
                 pick_gap(tx_mode), (i == 0 || i == 700));
    end

    wait (rst_n);
    while (pending_ticks.size() != 0 || in_valid || sent_cnt != recv_cnt)
      @(posedge clk);
    repeat (10) @(posedge clk);  // catch any stray result

    if (err_cnt == 0 && expected_scans.size() == 0) begin
      $display("led_matrix_temp_display_scanner: match");
    end else begin
      $display("led_matrix_temp_display_scanner: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("led_matrix_temp_display_scanner: mismatch");
    $finish;
  end

endmodule
